// ===== rtl/clt_pkg.sv =====
package clt_pkg;

    // table geometry and field widths
    localparam int CLT_SLOTS  = 8;
    localparam int CLT_ADDR_W = 32;
    localparam int CLT_TIME_W = 16;

    // request operation codes
    typedef enum logic [1:0] {
        MODE_RECORD = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_LOOKUP = 2'd2
    } t_mode;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } t_state;

    // one client slot as it travels along the ring
    typedef struct packed {
        logic                  valid;
        logic [CLT_ADDR_W-1:0] addr;
        logic [CLT_TIME_W-1:0] ltime;
    } t_slot;

    // one finished result
    typedef struct packed {
        logic                  hit;
        logic [2:0]            slot_index;
        logic                  stored;
        logic                  table_full;
        logic [3:0]            live_count;
        logic [CLT_TIME_W-1:0] max_remaining;
    } t_res;

endpackage

// ===== rtl/clt_if.sv =====
interface clt_req_if;
    import clt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            mode;
    logic [CLT_ADDR_W-1:0] client_ip;
    logic [CLT_TIME_W-1:0] lease_time;

    modport source (output valid, output mode, output client_ip, output lease_time,
                    input ready);
    modport sink   (input valid, input mode, input client_ip, input lease_time,
                    output ready);
endinterface

interface clt_rsp_if;
    import clt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [2:0]            slot_index;
    logic                  stored;
    logic                  table_full;
    logic [3:0]            live_count;
    logic [CLT_TIME_W-1:0] max_remaining;

    modport source (output valid, output hit, output slot_index, output stored,
                    output table_full, output live_count, output max_remaining,
                    input ready);
    modport sink   (input valid, input hit, input slot_index, input stored,
                    input table_full, input live_count, input max_remaining,
                    output ready);
endinterface

// ===== rtl/clt_cell.sv =====
module clt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  clt_pkg::t_slot i_next,
    output clt_pkg::t_slot o_slot
);
    import clt_pkg::*;

    t_slot r_slot;

    // slot register, takes its neighbor's contents on every shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_shift) begin
            r_slot <= i_next;
        end
    end

    assign o_slot = r_slot;

endmodule

// ===== rtl/clt_scan.sv =====
module clt_scan #(
    parameter  int SLOTS = clt_pkg::CLT_SLOTS,
    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CW    = $clog2(SLOTS + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_start,
    input  logic                           i_step,
    input  logic [1:0]                     i_mode,
    input  logic [clt_pkg::CLT_ADDR_W-1:0] i_ip,
    input  logic [clt_pkg::CLT_TIME_W-1:0] i_lease,
    input  logic [IW-1:0]                  i_idx,
    input  clt_pkg::t_slot                 i_slot,
    output clt_pkg::t_slot                 o_slot,
    output clt_pkg::t_res                  o_res_next,
    output clt_pkg::t_res                  o_res_held
);
    import clt_pkg::*;

    logic                  r_hit,    n_hit;
    logic                  r_placed, n_placed;
    logic [IW-1:0]         r_pidx,   n_pidx;
    logic [CW-1:0]         r_live,   n_live;
    logic [CLT_TIME_W-1:0] r_top,    n_top;
    logic                  w_match;

    // pack the running totals into a result for the current operation
    function automatic t_res f_fmt(logic [1:0] m, logic h, logic pl, logic [IW-1:0] pi,
                                   logic [CW-1:0] lv, logic [CLT_TIME_W-1:0] tp);
        t_res          res;
        logic [IW+2:0] wide_idx;
        logic [CW+3:0] wide_cnt;
        res      = '0;
        wide_idx = {3'b000, pi};
        wide_cnt = {4'b0000, lv};
        unique case (m)
            MODE_RECORD: begin
                res.hit        = pl & h;
                res.slot_index = pl ? wide_idx[2:0] : 3'd0;
                res.stored     = pl;
                res.table_full = ~pl;
            end
            MODE_TICK: begin
                res.live_count    = wide_cnt[3:0];
                res.max_remaining = tp;
            end
            MODE_LOOKUP: begin
                res.hit        = h;
                res.slot_index = wide_idx[2:0];
            end
            default: begin
                res = '0;
            end
        endcase
        return res;
    endfunction

    assign w_match = (i_slot.addr == i_ip);

    // one slot passes the shared compare unit per cycle while i_step is high
    always_comb begin
        o_slot   = i_slot;
        n_hit    = r_hit;
        n_placed = r_placed;
        n_pidx   = r_pidx;
        n_live   = r_live;
        n_top    = r_top;
        unique case (i_mode)
            MODE_RECORD: begin
                n_hit = r_hit | (i_slot.valid & w_match);
                if (!r_placed && (!i_slot.valid || w_match)) begin
                    o_slot.valid = 1'b1;
                    o_slot.addr  = i_ip;
                    o_slot.ltime = i_lease;
                    n_placed     = 1'b1;
                    n_pidx       = i_idx;
                end else if (w_match) begin
                    o_slot.ltime = i_lease;
                end
            end
            MODE_TICK: begin
                if (i_slot.valid) begin
                    if (i_slot.ltime <= CLT_TIME_W'(1)) begin
                        o_slot.valid = 1'b0;
                        o_slot.ltime = '0;
                    end else begin
                        o_slot.ltime = i_slot.ltime - CLT_TIME_W'(1);
                        n_live       = r_live + CW'(1);
                        if (o_slot.ltime > r_top) begin
                            n_top = o_slot.ltime;
                        end
                    end
                end
            end
            MODE_LOOKUP: begin
                if (!r_hit && i_slot.valid && w_match) begin
                    n_hit  = 1'b1;
                    n_pidx = i_idx;
                end
            end
            default: begin
                o_slot = i_slot;
            end
        endcase
    end

    // running totals, cleared when a request is taken
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hit    <= 1'b0;
            r_placed <= 1'b0;
            r_pidx   <= '0;
            r_live   <= '0;
            r_top    <= '0;
        end else if (i_step) begin
            r_hit    <= n_hit;
            r_placed <= n_placed;
            r_pidx   <= n_pidx;
            r_live   <= n_live;
            r_top    <= n_top;
        end
    end

    assign o_res_next = f_fmt(i_mode, n_hit, n_placed, n_pidx, n_live, n_top);
    assign o_res_held = f_fmt(i_mode, r_hit, r_placed, r_pidx, r_live, r_top);

endmodule

// ===== rtl/client_lease_timeout_table.sv =====
// Client lease table: SLOTS client slots, each with a valid mark, an IPv4
// address and a remaining lease time.
// i_req carries one request (mode, client_ip, lease_time); mode selects
// record, tick or lookup. o_rsp returns exactly one result per request.
// Both channels move a request on a clock edge with valid and ready high.
// The slots sit in a ring of cells that rotates one place per cycle
// during a walk, so every slot passes the single compare and update
// unit once per request. The result goes to the output register at the
// end of the walk, or once that register is free; no new request is
// taken until then, so the block works on one request at a time.
// The result sits in an output register; a stalled receiver holds it, a
// following request still runs its walk and then waits until the output
// register is free, with i_req.ready low meanwhile.
// Reset (i_rst_n low, synchronous) clears every slot to invalid, address
// 0 and time 0, and drops any pending result.
module client_lease_timeout_table #(
    parameter int SLOTS = clt_pkg::CLT_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clt_req_if.sink     i_req,
    clt_rsp_if.source   o_rsp
);
    import clt_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_state                r_state, n_state;
    logic [IW-1:0]         r_idx;
    logic [1:0]            r_mode;
    logic [CLT_ADDR_W-1:0] r_ip;
    logic [CLT_TIME_W-1:0] r_lease;
    logic                  r_out_valid;
    t_res                  r_out;

    logic w_start, w_step, w_last, w_out_free, w_load_next, w_load_held, w_ready;
    t_slot w_slot [SLOTS];
    t_slot w_ring_in;
    t_res  w_res_next, w_res_held;

    assign w_last     = (r_idx == IW'(SLOTS - 1));
    assign w_out_free = !r_out_valid || o_rsp.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_req.valid) n_state = ST_SCAN;
            ST_SCAN: if (w_last) n_state = w_out_free ? ST_IDLE : ST_HOLD;
            ST_HOLD: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_ready     = 1'b0;
        w_start     = 1'b0;
        w_step      = 1'b0;
        w_load_next = 1'b0;
        w_load_held = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_ready = 1'b1;
                w_start = i_req.valid;
            end
            ST_SCAN: begin
                w_step      = 1'b1;
                w_load_next = w_last && w_out_free;
            end
            ST_HOLD: begin
                w_load_held = w_out_free;
            end
            default: begin
                w_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // slot position counter for the walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_start) begin
            r_idx <= '0;
        end else if (w_step) begin
            r_idx <= w_last ? '0 : r_idx + IW'(1);
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_mode  <= i_req.mode;
            r_ip    <= i_req.client_ip;
            r_lease <= i_req.lease_time;
        end
    end

    // ring of slot cells, the head feeds the shared unit and the tail
    // takes its updated slot
    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        t_slot w_next;
        if (k == SLOTS - 1) begin : g_tail
            assign w_next = w_ring_in;
        end else begin : g_body
            assign w_next = w_slot[k+1];
        end
        clt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_step),
            .i_next  (w_next),
            .o_slot  (w_slot[k])
        );
    end

    clt_scan #(.SLOTS(SLOTS)) u_scan (
        .i_clk      (i_clk),
        .i_start    (w_start),
        .i_step     (w_step),
        .i_mode     (r_mode),
        .i_ip       (r_ip),
        .i_lease    (r_lease),
        .i_idx      (r_idx),
        .i_slot     (w_slot[0]),
        .o_slot     (w_ring_in),
        .o_res_next (w_res_next),
        .o_res_held (w_res_held)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_next || w_load_held) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_next) begin
            r_out <= w_res_next;
        end else if (w_load_held) begin
            r_out <= w_res_held;
        end
    end

    assign i_req.ready         = w_ready;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.hit           = r_out.hit;
    assign o_rsp.slot_index    = r_out.slot_index;
    assign o_rsp.stored        = r_out.stored;
    assign o_rsp.table_full    = r_out.table_full;
    assign o_rsp.live_count    = r_out.live_count;
    assign o_rsp.max_remaining = r_out.max_remaining;

endmodule

// ===== rtl/clt_checker.sv =====
module clt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic        i_rsp_hit,
    input logic        i_rsp_stored,
    input logic        i_rsp_table_full,
    input logic [3:0]  i_rsp_live_count,
    input logic [15:0] i_rsp_max_remaining
);

    // one request at a time: busy right after a request is taken
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while a walk is running");

    // a new result only appears at the end of a walk
    a_result_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> !$past(i_req_ready))
        else $error("result without a walk");

    // a record result is either stored or full, never both
    a_record_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_rsp_stored && i_rsp_table_full))
        else $error("record both stored and full");

    // tick results carry no record or lookup flags
    a_tick_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_live_count != 4'd0 || i_rsp_max_remaining != 16'd0))
        |-> !(i_rsp_hit || i_rsp_stored || i_rsp_table_full))
        else $error("tick result mixed with other fields");

    // stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)
        else $error("result dropped while stalled");

endmodule

bind client_lease_timeout_table clt_checker u_clt_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_req_valid         (i_req.valid),
    .i_req_ready         (i_req.ready),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_rsp_hit           (o_rsp.hit),
    .i_rsp_stored        (o_rsp.stored),
    .i_rsp_table_full    (o_rsp.table_full),
    .i_rsp_live_count    (o_rsp.live_count),
    .i_rsp_max_remaining (o_rsp.max_remaining)
);

// ===== tb/sv/lease_table_monitor.sv =====
`timescale 1ns / 100ps

module lease_table_monitor (
    input  logic i_clk,
    input  logic i_rst_n,
    clt_req_if   i_req,
    clt_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    import clt_pkg::*;

    // shadow copy of the client slots
    logic                  lease_valid [CLT_SLOTS];
    logic [CLT_ADDR_W-1:0] lease_addr  [CLT_SLOTS];
    logic [CLT_TIME_W-1:0] lease_left  [CLT_SLOTS];

    // results owed by the block, oldest first
    t_res owed_q[$];
    int   fail_total = 0;

    // apply one request to the shadow slots and return the result it should give
    function automatic t_res apply_lease_op(logic [1:0] mode, logic [CLT_ADDR_W-1:0] ip,
                                            logic [CLT_TIME_W-1:0] lt);
        t_res                  r;
        bit                    was_live;
        int                    first_free;
        int unsigned           live;
        logic [CLT_TIME_W-1:0] top;
        r          = '0;
        was_live   = 1'b0;
        first_free = -1;
        live       = 0;
        top        = '0;
        case (mode)
            MODE_RECORD: begin
                // every slot with this address gets the new lease, valid or not
                for (int i = 0; i < CLT_SLOTS; i++) begin
                    if (lease_addr[i] == ip) begin
                        lease_left[i] = lt;
                        if (lease_valid[i])
                            was_live = 1'b1;
                    end
                end
                // first slot that is free or already holds the client
                for (int i = 0; i < CLT_SLOTS; i++) begin
                    if (first_free < 0 && (!lease_valid[i] || lease_addr[i] == ip))
                        first_free = i;
                end
                if (first_free >= 0) begin
                    lease_valid[first_free] = 1'b1;
                    lease_left[first_free]  = lt;
                    lease_addr[first_free]  = ip;
                    r.hit        = was_live;
                    r.slot_index = first_free[2:0];
                    r.stored     = 1'b1;
                end else begin
                    r.table_full = 1'b1;
                end
            end
            MODE_TICK: begin
                // count down, expire at one or below
                for (int i = 0; i < CLT_SLOTS; i++) begin
                    if (lease_valid[i]) begin
                        if (lease_left[i] <= 1) begin
                            lease_left[i]  = '0;
                            lease_valid[i] = 1'b0;
                        end else begin
                            lease_left[i] = lease_left[i] - 1'b1;
                            live++;
                            if (lease_left[i] > top)
                                top = lease_left[i];
                        end
                    end
                end
                r.live_count    = live[3:0];
                r.max_remaining = top;
            end
            MODE_LOOKUP: begin
                // lowest valid slot holding the address
                for (int i = CLT_SLOTS - 1; i >= 0; i--) begin
                    if (lease_valid[i] && lease_addr[i] == ip) begin
                        r.hit        = 1'b1;
                        r.slot_index = i[2:0];
                    end
                end
            end
            default: begin
                // unused mode: no change, all fields zero
            end
        endcase
        return r;
    endfunction

    task automatic report_failure(string what, t_res want, t_res got);
        fail_total++;
        if (fail_total <= 10) begin
            $display("%t %s", $realtime, what);
            $display("  expected hit=%0d idx=%0d stored=%0d full=%0d live=%0d max=%0d",
                     want.hit, want.slot_index, want.stored, want.table_full,
                     want.live_count, want.max_remaining);
            $display("  actual   hit=%0d idx=%0d stored=%0d full=%0d live=%0d max=%0d",
                     got.hit, got.slot_index, got.stored, got.table_full,
                     got.live_count, got.max_remaining);
        end
    endtask

    // predict on each accepted request, compare on each accepted result
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            for (int i = 0; i < CLT_SLOTS; i++) begin
                lease_valid[i] = 1'b0;
                lease_addr[i]  = '0;
                lease_left[i]  = '0;
            end
            owed_q.delete();
        end else begin
            if (i_req.valid && i_req.ready)
                owed_q.push_back(apply_lease_op(i_req.mode, i_req.client_ip,
                                                i_req.lease_time));
            if (i_rsp.valid && i_rsp.ready) begin
                got.hit           = i_rsp.hit;
                got.slot_index    = i_rsp.slot_index;
                got.stored        = i_rsp.stored;
                got.table_full    = i_rsp.table_full;
                got.live_count    = i_rsp.live_count;
                got.max_remaining = i_rsp.max_remaining;
                if (owed_q.size() == 0) begin
                    report_failure("result with no request outstanding", '0, got);
                end else begin
                    want = owed_q.pop_front();
                    if (got.hit !== want.hit || got.slot_index !== want.slot_index ||
                        got.stored !== want.stored || got.table_full !== want.table_full ||
                        got.live_count !== want.live_count ||
                        got.max_remaining !== want.max_remaining)
                        report_failure("result mismatch", want, got);
                end
            end
        end
        o_pending = owed_q.size();
    end

    assign o_fail_count = fail_total;

endmodule

// ===== tb/sv/client_lease_timeout_table_tb.sv =====
`timescale 1ns / 100ps

module client_lease_timeout_table_tb;
    import clt_pkg::*;

    // mode value the block must ignore
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [31:0] IP_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] IP_A        = 32'h0A00_0001;
    localparam logic [31:0] IP_B        = 32'hC0A8_0110;

    localparam int RANDOM_ITEMS = 1925;
    localparam int POOL_SIZE    = 12;

    logic        i_clk;
    logic        i_rst_n;
    int unsigned cyc = 0;
    int          mon_fails;
    int          mon_pending;
    logic [31:0] addr_pool [POOL_SIZE];

    clt_req_if req_ch ();
    clt_rsp_if rsp_ch ();

    client_lease_timeout_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    lease_table_monitor u_lease_mon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (mon_fails),
        .o_pending    (mon_pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk)
        cyc <= cyc + 1;

    // stretch where neither side idles
    function automatic bit quiet_window();
        return cyc >= 6000 && cyc < 9000;
    endfunction

    // mostly a small pool so clients repeat, sometimes any address
    function automatic logic [31:0] pick_addr();
        if ($urandom_range(99) < 85)
            return addr_pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom;
    endfunction

    // mostly short leases so ticks expire slots
    function automatic logic [15:0] pick_lease();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return 16'($urandom_range(8));
        if (roll < 90)
            return 16'($urandom_range(300));
        if (roll < 98)
            return 16'($urandom);
        return 16'hFFFF;
    endfunction

    // phases alternate between balanced, filling and draining mixes
    function automatic logic [1:0] pick_mode(int unsigned k);
        int unsigned roll;
        int unsigned rec_lim;
        int unsigned tick_lim;
        int unsigned look_lim;
        roll = $urandom_range(99);
        case ((k / 150) % 3)
            0: begin rec_lim = 40; tick_lim = 70; look_lim = 95; end
            1: begin rec_lim = 60; tick_lim = 70; look_lim = 97; end
            default: begin rec_lim = 20; tick_lim = 75; look_lim = 97; end
        endcase
        if (roll < rec_lim)
            return MODE_RECORD;
        if (roll < tick_lim)
            return MODE_TICK;
        if (roll < look_lim)
            return MODE_LOOKUP;
        return MODE_UNUSED;
    endfunction

    // offer one request, called and returning at a falling edge
    task automatic send_req(logic [1:0] mode, logic [31:0] ip, logic [15:0] lt);
        int unsigned gap;
        gap = 0;
        if (!quiet_window() && $urandom_range(99) < 14)
            gap = $urandom_range(1, 12);
        if (gap != 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.mode       = mode;
        req_ch.client_ip  = ip;
        req_ch.lease_time = lt;
        req_ch.valid      = 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    // result receiver with random stalls and one long hold-off
    initial begin
        int unsigned since_rst;
        since_rst    = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (i_rst_n)
                since_rst++;
            if (since_rst >= 3000 && since_rst < 3400)
                rsp_ch.ready = 1'b0;
            else if (quiet_window())
                rsp_ch.ready = 1'b1;
            else
                rsp_ch.ready = ($urandom_range(99) >= 14);
        end
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // stimulus and verdict
    initial begin
        int unsigned k;
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.mode       = MODE_RECORD;
        req_ch.client_ip  = '0;
        req_ch.lease_time = '0;
        addr_pool[0] = '0;
        addr_pool[1] = IP_ALL_ONES;
        for (int i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = $urandom;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table: lookup of the cleared address misses, tick sees nothing
        send_req(MODE_LOOKUP, 32'h0, 16'h0);
        send_req(MODE_TICK, IP_ALL_ONES, 16'hFFFF);
        // address zero matches every cleared slot
        send_req(MODE_RECORD, 32'h0, 16'd5);
        send_req(MODE_RECORD, IP_ALL_ONES, 16'hFFFF);
        // zero lease, freed by the next tick
        send_req(MODE_RECORD, IP_A, 16'd0);
        send_req(MODE_LOOKUP, IP_ALL_ONES, 16'h0);
        send_req(MODE_TICK, 32'h0, 16'h0);
        send_req(MODE_LOOKUP, IP_A, 16'h0);
        // fill the rest, then overflow
        for (int i = 0; i < 6; i++)
            send_req(MODE_RECORD, IP_B + i, 16'(3 + i));
        send_req(MODE_RECORD, IP_A, 16'd9);
        // refresh a live client
        send_req(MODE_RECORD, IP_B + 3, 16'd20);
        send_req(MODE_UNUSED, IP_ALL_ONES, 16'hFFFF);
        // expire the shortest lease, then duplicate a later client into it
        repeat (3) send_req(MODE_TICK, 32'h0, 16'h0);
        send_req(MODE_RECORD, IP_B + 4, 16'd50);
        send_req(MODE_LOOKUP, IP_B + 4, 16'h0);
        send_req(MODE_TICK, IP_ALL_ONES, 16'hFFFF);

        // random traffic
        for (k = 0; k < RANDOM_ITEMS; k++)
            send_req(pick_mode(k), pick_addr(), pick_lease());
        req_ch.valid = 1'b0;

        while (mon_pending != 0)
            @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        if (mon_fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
